/* hdl/smst_pkg.sv */
// smst_pkg: shared widths, codes and the coefficient table of the septic smoothstep evaluator.
// Used by the horner cells, the axis datapath and the top level; depends on nothing.
package smst_pkg;

	localparam int AXES_DEF = 3;          // axes per point
	localparam int S_W     = 17;          // clamped parameter, unsigned 0..65536
	localparam int P_W     = 48;          // horner accumulator, Q32
	localparam int C_W     = 16;          // polynomial coefficient
	localparam int F_W     = 36;          // factor, Q24
	localparam int PT_W    = 32;          // start and end coordinates, Q16.16
	localparam int D_W     = PT_W + 1;    // end minus start
	localparam int OUT_W   = 40;          // result, Q24.16
	localparam int N_STEP  = 8;           // horner steps, one cell each
	localparam int IN_W    = 24;          // s_tdata width
	localparam int PP_W    = 20;          // path_param width
	localparam int ORDER_W = 3;

	localparam logic [S_W-1:0] ONE_Q16    = S_W'(65536);
	localparam logic [S_W-1:0] PEAK_HALF  = S_W'(32768);
	localparam logic [S_W-1:0] PEAK_ORD2  = S_W'(47422);

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_PEAK = 1'b1;

	localparam logic [1:0] ORD_POS  = 2'd0;
	localparam logic [1:0] ORD_VEL  = 2'd1;
	localparam logic [1:0] ORD_ACC  = 2'd2;
	localparam logic [1:0] ORD_JERK = 2'd3;

	typedef struct packed {
		logic       peak;
		logic       bad;
		logic [1:0] ord;
	} ctrl_t;

	// horner coefficients, highest degree at step 0
	function automatic logic signed [C_W-1:0] poly_coef(input logic [1:0] ord,
		input logic [2:0] step);
		logic signed [C_W-1:0] c;
		c = '0;
		case ({ord, step})
			{ORD_POS, 3'd0}:  c = -16'sd20;
			{ORD_POS, 3'd1}:  c = 16'sd70;
			{ORD_POS, 3'd2}:  c = -16'sd84;
			{ORD_POS, 3'd3}:  c = 16'sd35;
			{ORD_VEL, 3'd1}:  c = -16'sd140;
			{ORD_VEL, 3'd2}:  c = 16'sd420;
			{ORD_VEL, 3'd3}:  c = -16'sd420;
			{ORD_VEL, 3'd4}:  c = 16'sd140;
			{ORD_ACC, 3'd2}:  c = -16'sd840;
			{ORD_ACC, 3'd3}:  c = 16'sd2100;
			{ORD_ACC, 3'd4}:  c = -16'sd1680;
			{ORD_ACC, 3'd5}:  c = 16'sd420;
			{ORD_JERK, 3'd3}: c = -16'sd4200;
			{ORD_JERK, 3'd4}: c = 16'sd8400;
			{ORD_JERK, 3'd5}: c = -16'sd5040;
			{ORD_JERK, 3'd6}: c = 16'sd840;
			default:          c = '0;
		endcase
		return c;
	endfunction

endpackage

/* hdl/smoothstep7_blend_eval_top.sv */
// Septic smoothstep evaluator: takes one request per cycle while s_tready is high and returns
// one result per request, held while m_tready is low. Eight horner cells, one multiply
// each, form the polynomial value; four more stages per axis scale by end minus start, round,
// add the start point for position and saturate. Each stage moves whenever its successor can
// take data, so bubbles close up and input is taken while a result waits at the output. Start
// and end points are written via the cfg port with no request in flight; the user ensures it.
module smoothstep7_blend_eval_top
	import smst_pkg::*;
#(
	parameter int AXES = AXES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [$clog2(2*AXES)-1:0]     cfg_index,
	input  logic [PT_W-1:0]               cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [IN_W-1:0]               s_tdata,   // order[2:0], path_param[22:3], zero pad
	input  logic                          s_tuser,   // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [AXES*OUT_W-1:0]         m_tdata,   // value per axis, 40 bits each, x first
	output logic                          m_tuser    // bad_order
);

	localparam int NST = N_STEP + 5;

	logic signed [PT_W-1:0] start_q [AXES];
	logic signed [PT_W-1:0] end_q   [AXES];

	logic [NST-1:0]         en;
	logic [NST-1:0]         vld;
	logic [N_STEP-1:0]      vld_chain;
	logic [4:0]             vld_q;

	logic [ORDER_W-1:0]     ord_in;
	logic signed [PP_W-1:0] pp_in;
	logic [S_W-1:0]         s_in;
	ctrl_t                  ctrl_in;

	logic signed [P_W-1:0]  p_end;
	ctrl_t                  ctrl_end;
	logic signed [P_W-1:0]  f_rnd;
	logic signed [F_W-1:0]  f_s8;
	ctrl_t                  ctrl_s8;
	ctrl_t                  ctrl_s9;
	ctrl_t                  ctrl_s10;
	ctrl_t                  ctrl_s11;
	logic                   bad_s12;

	// configuration writes, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				start_q[a] <= '0;
				end_q[a]   <= '0;
			end
		end else if (cfg_we) begin
			for (int a = 0; a < AXES; a++) begin
				if (cfg_index == $bits(cfg_index)'(a)) begin
					start_q[a] <= $signed(cfg_data);
				end
				if (cfg_index == $bits(cfg_index)'(a + AXES)) begin
					end_q[a] <= $signed(cfg_data);
				end
			end
		end
	end

	// request decode, clamp and peak parameter
	always_comb begin
		ord_in       = s_tdata[ORDER_W-1:0];
		pp_in        = $signed(s_tdata[ORDER_W+PP_W-1:ORDER_W]);
		ctrl_in.peak = (s_tuser == KIND_PEAK);
		ctrl_in.ord  = ord_in[1:0];
		ctrl_in.bad  = ord_in[2] || (ctrl_in.peak && ord_in[1:0] == ORD_POS);
		if (ctrl_in.peak) begin
			s_in = (ord_in[1:0] == ORD_ACC) ? PEAK_ORD2 : PEAK_HALF;
		end else if (pp_in < 0) begin
			s_in = '0;
		end else if (pp_in > $signed(PP_W'(ONE_Q16))) begin
			s_in = ONE_Q16;
		end else begin
			s_in = pp_in[S_W-1:0];
		end
	end

	// a stage takes new data when it is empty or its successor moves
	assign vld = {vld_q, vld_chain};

	always_comb begin
		en[NST-1] = !vld[NST-1] || m_tready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign s_tready = en[0];

	smst_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[N_STEP-1:0]),
		.vld_in   (s_tvalid),
		.s_in     (s_in),
		.ctrl_in  (ctrl_in),
		.vld      (vld_chain),
		.p_out    (p_end),
		.ctrl_out (ctrl_end)
	);

	assign f_rnd = (p_end + P_W'(128)) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[N_STEP]) begin
				vld_q[0] <= vld[N_STEP-1];
			end
			for (int k = 1; k < 5; k++) begin
				if (en[N_STEP+k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[N_STEP]) begin
			f_s8    <= F_W'(f_rnd);
			ctrl_s8 <= ctrl_end;
		end
		if (en[N_STEP+1]) begin
			ctrl_s9 <= ctrl_s8;
		end
		if (en[N_STEP+2]) begin
			ctrl_s10 <= ctrl_s9;
		end
		if (en[N_STEP+3]) begin
			ctrl_s11 <= ctrl_s10;
		end
		if (en[N_STEP+4]) begin
			bad_s12 <= ctrl_s11.bad;
		end
	end

	for (genvar a = 0; a < AXES; a++) begin : g_axis
		smst_axis u_axis (
			.clk      (clk),
			.adv      (en[NST-1:N_STEP+1]),
			.f        (f_s8),
			.start_pt (start_q[a]),
			.end_pt   (end_q[a]),
			.ctrl_s10 (ctrl_s10),
			.ctrl_s11 (ctrl_s11),
			.value    (m_tdata[a*OUT_W +: OUT_W])
		);
	end

	assign m_tvalid = vld[NST-1];
	assign m_tuser  = bad_s12;

endmodule

/* hdl/smst_horner_cell.sv */
// smst_horner_cell: one horner step p = round(p*s/2^16) + c*2^32, registered.
// Depends on smst_pkg for widths, the control struct and the coefficient table.
module smst_horner_cell
	import smst_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic signed [P_W-1:0] p_in,
	input  logic [S_W-1:0]        s_in,
	input  ctrl_t                 ctrl_in,
	output logic                  vld_out,
	output logic signed [P_W-1:0] p_out,
	output logic [S_W-1:0]        s_out,
	output ctrl_t                 ctrl_out
);

	localparam int M_W = P_W + S_W + 1;

	logic signed [M_W-1:0] mul;
	logic signed [M_W-1:0] rnd;
	logic signed [P_W-1:0] c_sh;
	logic signed [P_W-1:0] p_nxt;
	logic                  vld_q;
	logic signed [P_W-1:0] p_q;
	logic [S_W-1:0]        s_q;
	ctrl_t                 ctrl_q;

	always_comb begin
		mul   = M_W'(p_in) * $signed({1'b0, s_in});
		rnd   = (mul + M_W'(32768)) >>> 16;
		c_sh  = P_W'(poly_coef(ctrl_in.ord, 3'(STEP))) <<< 32;
		p_nxt = $signed(rnd[P_W-1:0]) + c_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_q    <= p_nxt;
			s_q    <= s_in;
			ctrl_q <= ctrl_in;
		end
	end

	assign vld_out  = vld_q;
	assign p_out    = p_q;
	assign s_out    = s_q;
	assign ctrl_out = ctrl_q;

endmodule

/* hdl/smst_axis.sv */
// smst_axis: per-axis scaling of the factor by end minus start, rounding, offset and saturation.
// Depends on smst_pkg; four pipeline stages advanced by the top level.
module smst_axis
	import smst_pkg::*;
(
	input  logic                    clk,
	input  logic [3:0]              adv,       // stage enables, lowest first
	input  logic signed [F_W-1:0]   f,
	input  logic signed [PT_W-1:0]  start_pt,
	input  logic signed [PT_W-1:0]  end_pt,
	input  ctrl_t                   ctrl_s10,
	input  ctrl_t                   ctrl_s11,
	output logic signed [OUT_W-1:0] value
);

	localparam int LO_W = 17;
	localparam int HI_W = D_W - LO_W;
	localparam int PR_W = F_W + D_W + 1;
	localparam int V_W  = PR_W - 24 + 1;

	logic signed [D_W-1:0]       d;
	logic signed [F_W+LO_W:0]    lo_s9;
	logic signed [F_W+HI_W-1:0]  hi_s9;
	logic signed [PR_W-1:0]      prod_s10;
	logic signed [PR_W-1:0]      rnd;
	logic signed [V_W-1:0]       v_nxt;
	logic signed [V_W-1:0]       v_s11;
	logic signed [OUT_W-1:0]     sat;
	logic signed [OUT_W-1:0]     o_nxt;
	logic signed [OUT_W-1:0]     o_s12;

	assign d = D_W'(end_pt) - D_W'(start_pt);

	always_comb begin
		rnd   = (prod_s10 + PR_W'(1 << 23)) >>> 24;
		v_nxt = V_W'(rnd);
		if (ctrl_s10.ord == ORD_POS) begin
			v_nxt = v_nxt + V_W'(start_pt);
		end
	end

	always_comb begin
		if (v_s11 > V_W'(OUT_MAX)) begin
			sat = OUT_MAX;
		end else if (v_s11 < V_W'(OUT_MIN)) begin
			sat = OUT_MIN;
		end else begin
			sat = OUT_W'(v_s11);
		end
		o_nxt = sat;
		if (ctrl_s11.peak && sat < 0) begin
			o_nxt = (sat == OUT_MIN) ? OUT_MAX : -sat;
		end
		if (ctrl_s11.bad) begin
			o_nxt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lo_s9 <= f * $signed({1'b0, d[LO_W-1:0]});
			hi_s9 <= f * $signed(d[D_W-1:LO_W]);
		end
		if (adv[1]) begin
			prod_s10 <= (PR_W'(hi_s9) <<< LO_W) + PR_W'(lo_s9);
		end
		if (adv[2]) begin
			v_s11 <= v_nxt;
		end
		if (adv[3]) begin
			o_s12 <= o_nxt;
		end
	end

	assign value = o_s12;

endmodule

/* hdl/smst_chain.sv */
// smst_chain: row of horner cells that turns a clamped parameter into the Q32 polynomial value.
// Depends on smst_pkg and smst_horner_cell.
module smst_chain
	import smst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [N_STEP-1:0]     en,
	input  logic                  vld_in,
	input  logic [S_W-1:0]        s_in,
	input  ctrl_t                 ctrl_in,
	output logic [N_STEP-1:0]     vld,
	output logic signed [P_W-1:0] p_out,
	output ctrl_t                 ctrl_out
);

	logic signed [P_W-1:0] p_c    [N_STEP+1];
	logic [S_W-1:0]        s_c    [N_STEP+1];
	ctrl_t                 ctrl_c [N_STEP+1];
	logic [N_STEP:0]       vld_c;

	assign p_c[0]    = '0;
	assign s_c[0]    = s_in;
	assign ctrl_c[0] = ctrl_in;
	assign vld_c[0]  = vld_in;

	for (genvar k = 0; k < N_STEP; k++) begin : g_cell
		smst_horner_cell #(
			.STEP(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[k]),
			.vld_in   (vld_c[k]),
			.p_in     (p_c[k]),
			.s_in     (s_c[k]),
			.ctrl_in  (ctrl_c[k]),
			.vld_out  (vld_c[k+1]),
			.p_out    (p_c[k+1]),
			.s_out    (s_c[k+1]),
			.ctrl_out (ctrl_c[k+1])
		);
	end

	assign vld      = vld_c[N_STEP:1];
	assign p_out    = p_c[N_STEP];
	assign ctrl_out = ctrl_c[N_STEP];

endmodule
